[hw/rtl/rau_pkg.sv]
// Shared types, constants and helpers for the rational arithmetic unit.
// Used by rau_unit, rational_arithmetic_unit_top and tb_top; no other dependencies.
package rau_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int WW          = 2 * VALUE_WIDTH;
  localparam int CNT_W       = $clog2(WW);

  localparam logic [WW-1:0] HALF    = {{(WW-VALUE_WIDTH){1'b0}}, 1'b1,
                                       {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [WW-1:0] HALF_M1 = HALF - {{(WW-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    OPC_ADD = 3'd0,
    OPC_SUB = 3'd1,
    OPC_MUL = 3'd2,
    OPC_DIV = 3'd3,
    OPC_LT  = 3'd4,
    OPC_EQ  = 3'd5
  } opc_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZDEN = 2'd1,
    STAT_DIVZ = 2'd2,
    STAT_OVF  = 2'd3
  } stat_t;

  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } uop_t;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_R = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD,
    ST_GCD_W,
    ST_DIVN,
    ST_DIVN_W,
    ST_DIVD,
    ST_DIVD_W,
    ST_MUL1,
    ST_MUL1_W,
    ST_MUL2,
    ST_MUL2_W,
    ST_MUL3,
    ST_MUL3_W,
    ST_COMB,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        flag;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic          start;
    uop_t          op;
    logic [WW-1:0] opa;
    logic [WW-1:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic          done;
    logic [WW-1:0] q;
    logic [WW-1:0] r;
  } unit_rsp_t;

  // magnitude of the low VALUE_WIDTH bits read as two's complement
  function automatic logic [VALUE_WIDTH-1:0] mag_of(input logic [31:0] raw);
    logic [VALUE_WIDTH-1:0] u;
    u = raw[VALUE_WIDTH-1:0];
    mag_of = u[VALUE_WIDTH-1] ? (~u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : u;
  endfunction

  function automatic logic [WW-1:0] zext(input logic [VALUE_WIDTH-1:0] v);
    zext = {{(WW-VALUE_WIDTH){1'b0}}, v};
  endfunction

endpackage

[hw/rtl/rau_unit.sv]
// Shared iterative arithmetic unit: shift-add multiplier and restoring divider.
// Depends on rau_pkg.
module rau_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  uop_t             uop_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WW-1:0]    acc_r;
  logic [WW-1:0]    sh_r;
  logic [WW-1:0]    aux_r;

  logic [WW:0]      shifted;
  logic [WW:0]      diff;
  logic             ge;
  logic             last;

  assign shifted = {acc_r, sh_r[WW-1]};
  assign diff    = shifted - {1'b0, aux_r};
  assign ge      = ~diff[WW];
  assign last    = (uop_r == UOP_MUL) ? (cnt_r == CNT_W'(VALUE_WIDTH - 1))
                                      : (cnt_r == CNT_W'(WW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      uop_r <= req.op;
      cnt_r <= '0;
      acc_r <= '0;
      sh_r  <= req.opa;
      aux_r <= req.opb;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      unique case (uop_r)
        UOP_MUL: begin
          if (aux_r[0]) begin
            acc_r <= acc_r + sh_r;
          end
          sh_r  <= {sh_r[WW-2:0], 1'b0};
          aux_r <= {1'b0, aux_r[WW-1:1]};
        end
        UOP_DIV: begin
          // restoring step: keep the difference when no borrow
          acc_r <= ge ? diff[WW-1:0] : shifted[WW-1:0];
          sh_r  <= {sh_r[WW-2:0], ge};
        end
        default: ;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = (uop_r == UOP_MUL) ? acc_r : sh_r;
  assign rsp.r    = acc_r;

endmodule

[hw/rtl/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: sequencer and fraction datapath.
// Depends on rau_pkg and rau_unit.
//
// One transaction is taken when start is high and busy is low. Busy then stays
// high until the cycle in which the result is strobed on out_valid. The result
// is on the ports for that one cycle only, and the receiver must take it as it
// comes. All work runs on one shared unit. Compares, division by zero and
// unknown opcodes skip the result reduction. A zero denominator in either
// operand ends the transaction straight from the check state with status
// STAT_ZDEN.
module rational_arithmetic_unit_top import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  state_t                 state_r, state_nxt;
  phase_t                 phase_r;
  in_item_t               in_r;
  logic [WW-1:0]          x_r, y_r, rn_r, rd_r;
  logic                   rneg_r;
  logic [VALUE_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic                   aneg_r, bneg_r;
  logic [WW-1:0]          t1_r, t2_r, dd_r;
  logic [31:0]            res_num_r;
  logic [30:0]            res_den_r;
  logic                   flag_r;
  stat_t                  status_r;
  logic                   out_valid_r;

  unit_req_t              req;
  unit_rsp_t              rsp;

  logic [VALUE_WIDTH-1:0] a_nm, a_dm, b_nm, b_dm;
  logic                   a_sg, b_sg;
  logic                   s2_adj, sum_sg;
  logic [WW-1:0]          sum_m;
  logic [WW-1:0]          den_v;
  logic                   ovf;
  logic [VALUE_WIDTH-1:0] num_v;
  opc_t                   opc;

  rau_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign opc  = opc_t'(in_r.opcode);
  assign a_nm = mag_of(in_r.a_num);
  assign a_dm = mag_of(in_r.a_den);
  assign b_nm = mag_of(in_r.b_num);
  assign b_dm = mag_of(in_r.b_den);
  assign a_sg = in_r.a_num[VALUE_WIDTH-1] ^ in_r.a_den[VALUE_WIDTH-1];
  assign b_sg = in_r.b_num[VALUE_WIDTH-1] ^ in_r.b_den[VALUE_WIDTH-1];

  // signed sum or difference of the cross products
  always_comb begin
    s2_adj = bneg_r ^ ((opc == OPC_SUB) && (t2_r != '0));
    if (aneg_r == s2_adj) begin
      sum_m  = t1_r + t2_r;
      sum_sg = aneg_r;
    end else if (t1_r >= t2_r) begin
      sum_m  = t1_r - t2_r;
      sum_sg = aneg_r;
    end else begin
      sum_m  = t2_r - t1_r;
      sum_sg = s2_adj;
    end
  end

  // a zero numerator gets denominator 1
  assign den_v = (rn_r == '0) ? {{(WW-1){1'b0}}, 1'b1} : rsp.q;
  assign ovf   = (rneg_r ? (rn_r > HALF) : (rn_r > HALF_M1)) || (rd_r > HALF_M1);
  assign num_v = rneg_r ? (~rn_r[VALUE_WIDTH-1:0] + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
                        : rn_r[VALUE_WIDTH-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ((a_dm == '0) || (b_dm == '0)) ? ST_DONE : ST_GCD;
      ST_GCD:    state_nxt = (y_r == '0) ? ST_DIVN : ST_GCD_W;
      ST_GCD_W:  if (rsp.done) state_nxt = ST_GCD;
      ST_DIVN:   state_nxt = ST_DIVN_W;
      ST_DIVN_W: if (rsp.done) state_nxt = ST_DIVD;
      ST_DIVD:   state_nxt = ST_DIVD_W;
      ST_DIVD_W: begin
        if (rsp.done) begin
          unique case (phase_r)
            PH_A:    state_nxt = ST_GCD;
            PH_B:    state_nxt = ST_MUL1;
            default: state_nxt = ST_FINAL;
          endcase
        end
      end
      ST_MUL1:   state_nxt = ST_MUL1_W;
      ST_MUL1_W: if (rsp.done) state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_MUL2_W;
      ST_MUL2_W: if (rsp.done) state_nxt = ST_MUL3;
      ST_MUL3:   state_nxt = ST_MUL3_W;
      ST_MUL3_W: if (rsp.done) state_nxt = ST_COMB;
      ST_COMB: begin
        case (opc) inside
          OPC_ADD, OPC_SUB, OPC_MUL: state_nxt = ST_GCD;
          OPC_DIV: state_nxt = (bn_r == '0) ? ST_DONE : ST_GCD;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_FINAL:  state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // requests to the shared unit
  always_comb begin
    req.start = 1'b0;
    req.op    = UOP_DIV;
    req.opa   = '0;
    req.opb   = '0;
    unique case (state_r)
      ST_GCD: begin
        req.start = (y_r != '0);
        req.opa   = x_r;
        req.opb   = y_r;
      end
      ST_DIVN: begin
        req.start = 1'b1;
        req.opa   = rn_r;
        req.opb   = x_r;
      end
      ST_DIVD: begin
        req.start = 1'b1;
        req.opa   = rd_r;
        req.opb   = x_r;
      end
      ST_MUL1: begin
        req.start = 1'b1;
        req.op    = UOP_MUL;
        req.opa   = zext(an_r);
        req.opb   = zext((opc == OPC_MUL) ? bn_r : bd_r);
      end
      ST_MUL2: begin
        req.start = 1'b1;
        req.op    = UOP_MUL;
        req.opa   = zext(bn_r);
        req.opb   = zext(ad_r);
      end
      ST_MUL3: begin
        req.start = 1'b1;
        req.op    = UOP_MUL;
        req.opa   = zext(ad_r);
        req.opb   = zext((opc == OPC_DIV) ? bn_r : bd_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) in_r <= in_data;
      end
      ST_CHECK: begin
        if ((a_dm == '0) || (b_dm == '0)) begin
          res_num_r <= '0;
          res_den_r <= '0;
          flag_r    <= 1'b0;
          status_r  <= STAT_ZDEN;
        end else begin
          rn_r    <= zext(a_nm);
          rd_r    <= zext(a_dm);
          x_r     <= zext(a_nm);
          y_r     <= zext(a_dm);
          rneg_r  <= a_sg;
          phase_r <= PH_A;
        end
      end
      ST_GCD_W: begin
        if (rsp.done) begin
          x_r <= y_r;
          y_r <= rsp.r;
        end
      end
      ST_DIVN_W: begin
        if (rsp.done) rn_r <= rsp.q;
      end
      ST_DIVD_W: begin
        if (rsp.done) begin
          unique case (phase_r)
            PH_A: begin
              an_r    <= rn_r[VALUE_WIDTH-1:0];
              ad_r    <= den_v[VALUE_WIDTH-1:0];
              aneg_r  <= rneg_r && (rn_r != '0);
              // load the right fraction
              rn_r    <= zext(b_nm);
              rd_r    <= zext(b_dm);
              x_r     <= zext(b_nm);
              y_r     <= zext(b_dm);
              rneg_r  <= b_sg;
              phase_r <= PH_B;
            end
            PH_B: begin
              bn_r   <= rn_r[VALUE_WIDTH-1:0];
              bd_r   <= den_v[VALUE_WIDTH-1:0];
              bneg_r <= rneg_r && (rn_r != '0);
            end
            default: begin
              rd_r   <= den_v;
              rneg_r <= rneg_r && (rn_r != '0);
            end
          endcase
        end
      end
      ST_MUL1_W: if (rsp.done) t1_r <= rsp.q;
      ST_MUL2_W: if (rsp.done) t2_r <= rsp.q;
      ST_MUL3_W: if (rsp.done) dd_r <= rsp.q;
      ST_COMB: begin
        res_num_r <= '0;
        res_den_r <= 31'd1;
        flag_r    <= 1'b0;
        status_r  <= STAT_OK;
        phase_r   <= PH_R;
        case (opc) inside
          OPC_ADD, OPC_SUB: begin
            rn_r   <= sum_m;
            rd_r   <= dd_r;
            x_r    <= sum_m;
            y_r    <= dd_r;
            rneg_r <= sum_sg;
          end
          OPC_MUL, OPC_DIV: begin
            rn_r   <= t1_r;
            rd_r   <= dd_r;
            x_r    <= t1_r;
            y_r    <= dd_r;
            rneg_r <= aneg_r ^ bneg_r;
            if ((opc == OPC_DIV) && (bn_r == '0)) begin
              res_den_r <= '0;
              status_r  <= STAT_DIVZ;
            end
          end
          OPC_LT: begin
            if (aneg_r != bneg_r) flag_r <= aneg_r;
            else if (!aneg_r)     flag_r <= (t1_r < t2_r);
            else                  flag_r <= (t1_r > t2_r);
          end
          OPC_EQ: begin
            flag_r <= (aneg_r == bneg_r) && (an_r == bn_r) && (ad_r == bd_r);
          end
          default: ;
        endcase
      end
      ST_FINAL: begin
        flag_r <= 1'b0;
        if (ovf) begin
          res_num_r <= '0;
          res_den_r <= '0;
          status_r  <= STAT_OVF;
        end else begin
          res_num_r <= 32'(signed'(num_v));
          res_den_r <= rd_r[30:0];
          status_r  <= STAT_OK;
        end
      end
      default: ;
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_data.res_num = res_num_r;
  assign out_data.res_den = res_den_r;
  assign out_data.flag    = flag_r;
  assign out_data.status  = status_r;

endmodule

[tb/tb_top.sv]
// Self-checking bench for rational_arithmetic_unit_top: directed and random
// fraction pairs, checked against an in-bench fraction predictor. Uses rau_pkg.
`timescale 1ns / 100ps

module tb_top;
  import rau_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  in_item_t  pending_q[$];
  int        gap_q[$];
  out_item_t result_q[$];
  int        gap_cnt;
  int        n_fail;
  int        n_taken;
  int        n_total;

  rational_arithmetic_unit_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic void split_raw(input logic [31:0] raw, output bit neg,
                                    output longint unsigned mag);
    neg = raw[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
  endfunction

  function automatic void reduce_frac(input bit neg, input longint unsigned n,
                                      input longint unsigned d, output bit r_neg,
                                      output longint unsigned r_n,
                                      output longint unsigned r_d);
    longint unsigned x, y, t;
    x = n;
    y = d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 1;
    r_n = n / x;
    r_d = d / x;
    r_neg = neg;
    if (r_n == 0) begin
      r_neg = 1'b0;
      r_d = 1;
    end
  endfunction

  function automatic out_item_t predict_fraction(input in_item_t it);
    out_item_t       o;
    bit              sn, sd, an, bn, s1, s2, rneg, sg, ovf;
    longint unsigned mn, md, aa, ad, ba, bd, t1, t2, m, rn, rd;
    logic [2:0]      op;
    op = it.opcode;
    o.res_num = '0;
    o.res_den = 31'd1;
    o.flag    = 1'b0;
    o.status  = STAT_OK;
    split_raw(it.a_den, sd, ad);
    split_raw(it.b_den, sd, bd);
    if (ad == 0 || bd == 0) begin
      o.res_den = '0;
      o.status  = STAT_ZDEN;
      return o;
    end
    split_raw(it.a_num, sn, mn);
    split_raw(it.a_den, sd, md);
    reduce_frac(sn != sd, mn, md, an, aa, ad);
    split_raw(it.b_num, sn, mn);
    split_raw(it.b_den, sd, md);
    reduce_frac(sn != sd, mn, md, bn, ba, bd);
    t1 = aa * bd;
    t2 = ba * ad;
    s1 = an;
    s2 = bn;
    case (op)
      OPC_ADD, OPC_SUB: begin
        if (op == OPC_SUB && t2 != 0) s2 = !s2;
        if (s1 == s2) begin
          m = t1 + t2;
          sg = s1;
        end else if (t1 >= t2) begin
          m = t1 - t2;
          sg = s1;
        end else begin
          m = t2 - t1;
          sg = s2;
        end
        reduce_frac(sg, m, ad * bd, rneg, rn, rd);
      end
      OPC_MUL: reduce_frac(an != bn, aa * ba, ad * bd, rneg, rn, rd);
      OPC_DIV: begin
        if (ba == 0) begin
          o.res_den = '0;
          o.status  = STAT_DIVZ;
          return o;
        end
        reduce_frac(an != bn, t1, ad * ba, rneg, rn, rd);
      end
      OPC_LT: begin
        if (s1 != s2) o.flag = s1;
        else if (!s1) o.flag = (t1 < t2);
        else o.flag = (t1 > t2);
        return o;
      end
      OPC_EQ: begin
        o.flag = (an == bn && aa == ba && ad == bd);
        return o;
      end
      default: return o;
    endcase
    ovf = (rneg ? (rn > 64'h8000_0000) : (rn > 64'h7FFF_FFFF)) || (rd > 64'h7FFF_FFFF);
    if (ovf) begin
      o.res_den = '0;
      o.status  = STAT_OVF;
    end else begin
      o.res_num = rneg ? (32'd0 - rn[31:0]) : rn[31:0];
      o.res_den = rd[30:0];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    bit taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        result_q.push_back(predict_fraction(in_data));
        n_taken++;
      end
      if (!start || taken) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data <= pending_q.pop_front();
          gap_cnt = gap_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result: %p", out_data);
      end else begin
        want = result_q.pop_front();
        if (want.res_num !== out_data.res_num || want.res_den !== out_data.res_den ||
            want.flag !== out_data.flag || want.status !== out_data.status) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [31:0] pick_value(input int mode);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: begin
        if (mode == 0) return 32'($signed($urandom_range(0, 100)) - 50);
        if (mode == 1) return 32'($signed($urandom_range(0, 200000)) - 100000);
        return $urandom;
      end
    endcase
  endfunction

  task automatic add_item(input logic [2:0] op, input logic [31:0] an,
                          input logic [31:0] ad, input logic [31:0] bn,
                          input logic [31:0] bd, input int gap);
    in_item_t it;
    it.opcode = op;
    it.a_num  = an;
    it.a_den  = ad;
    it.b_num  = bn;
    it.b_den  = bd;
    pending_q.push_back(it);
    gap_q.push_back(gap);
    n_total++;
  endtask

  initial begin
    int lazy, mode;
    logic [2:0] op;
    logic [31:0] ad, bd;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    gap_cnt = 0;
    n_fail = 0;
    n_taken = 0;
    n_total = 0;

    // directed: each operation, reduction, sign handling, extremes, errors
    add_item(OPC_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0);
    add_item(OPC_SUB, 32'd1, 32'd2, 32'd3, 32'd4, 0);
    add_item(OPC_MUL, -32'sd6, 32'd4, 32'd2, -32'sd3, 1);
    add_item(OPC_DIV, 32'd3, 32'd5, -32'sd9, 32'd10, 0);
    add_item(OPC_LT, -32'sd1, 32'd2, 32'd1, 32'd3, 2);
    add_item(OPC_LT, -32'sd1, 32'd2, -32'sd1, 32'd3, 0);
    add_item(OPC_EQ, 32'd2, 32'd4, -32'sd3, -32'sd6, 0);
    add_item(OPC_EQ, 32'd0, 32'd7, 32'd0, -32'sd5, 0);
    add_item(OPC_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 0);
    add_item(OPC_LT, 32'd1, 32'd1, 32'd1, 32'd0, 3);
    add_item(OPC_DIV, 32'd1, 32'd2, 32'd0, 32'd9, 0);
    add_item(OPC_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1, 0);
    add_item(OPC_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1, 0);
    add_item(OPC_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1, 0);
    add_item(OPC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    add_item(OPC_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE, 0);
    add_item(OPC_SUB, 32'd5, 32'd3, 32'd5, 32'd3, 0);
    add_item(3'd6, 32'd1, 32'd2, 32'd3, 32'd4, 0);
    add_item(3'd7, 32'd1, 32'd0, 32'd3, 32'd4, 0);
    add_item(OPC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_item(OPC_EQ, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 0);

    // random: mostly small values to keep gcd chains short, some full width
    lazy = 0;
    for (int i = 0; i < 1630; i++) begin
      if (i % 64 == 0) lazy = $urandom_range(0, 2);
      mode = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 3) == 0) ? 2 : 1);
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ad = ($urandom_range(0, 24) == 0) ? 32'd0 : pick_value(mode);
      bd = ($urandom_range(0, 24) == 0) ? 32'd0 : pick_value(mode);
      add_item(op, pick_value(mode), ad, ($urandom_range(0, 9) == 0) ? 32'd0 : pick_value(mode),
               bd, (lazy == 0) ? 0 : $urandom_range(0, 13));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_total || result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_unit.sv
hw/rtl/rational_arithmetic_unit_top.sv
tb/tb_top.sv
